/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the voice RTL.
// Each macro carries its own label, clock, reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SSV_ASSERT(lbl, clk, rstn, prop, msg)
`define SSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/ssv_pkg.sv */
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types and constants of the stereo sample-playback voice.
// ----------------------------------------------------------------------------
package ssv_pkg;

    localparam logic [3:0] CMD_LOAD       = 4'd0;
    localparam logic [3:0] CMD_RENDER     = 4'd1;
    localparam logic [3:0] CMD_TICK       = 4'd2;
    localparam logic [3:0] CMD_START      = 4'd3;
    localparam logic [3:0] CMD_SETVOL     = 4'd4;
    localparam logic [3:0] CMD_SETTARGET  = 4'd5;
    localparam logic [3:0] CMD_PAUSE      = 4'd6;
    localparam logic [3:0] CMD_RESUME     = 4'd7;
    localparam logic [3:0] CMD_FADEPAUSE  = 4'd8;
    localparam logic [3:0] CMD_FADESTOP   = 4'd9;
    localparam logic [3:0] CMD_FADEIN     = 4'd10;
    localparam logic [3:0] CMD_STOP       = 4'd11;

    localparam logic [1:0] REG_STEP_RATIO  = 2'd0;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
    localparam logic [1:0] REG_LOOP_START  = 2'd2;
    localparam logic [1:0] REG_LOOP_ENABLE = 2'd3;

    localparam logic [15:0] VOL_DEFAULT     = 16'd6554;
    localparam logic [19:0] STEP_RATIO_RST  = 20'd65536;

    typedef struct packed {
        logic [3:0]  command;
        logic [15:0] frame_address;
        logic [15:0] sample_left;
        logic [15:0] sample_right;
        logic [15:0] mix_left;
        logic [15:0] mix_right;
        logic [15:0] fade_steps;
        logic [15:0] volume_value;
    } item_t;

    typedef struct packed {
        logic [19:0] step_ratio;
        logic [16:0] frame_count;
        logic [15:0] loop_start;
        logic        loop_enable;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic rd_first;
        logic rd_second;
        logic mul_interp;
        logic mul_volume;
        logic out_load;
        logic fo_start;
        logic fo_apply;
        logic fi_start;
        logic fi_apply;
    } ctl_cmd_t;

    typedef struct packed {
        logic [3:0] command;
        logic       render_ok;
        logic       tick_fade;
        logic       fo_en;
        logic       fo_rpos;
        logic       fi_en;
        logic       fi_rpos;
        logic       div_done;
    } dp_stat_t;

endpackage

/* hw/rtl/ssv_datapath.sv */
// ----------------------------------------------------------------------------
// ssv_datapath
// Sample memory, voice state, interpolation/volume pipeline and fade divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssv_datapath
    import ssv_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  item_t       s_item,
    input  cfg_t        cfg,
    input  ctl_cmd_t    cmd,
    output dp_stat_t    stat,
    output logic [15:0] out_left,
    output logic [15:0] out_right,
    output logic        voice_active,
    output logic        voice_paused,
    output logic [15:0] current_volume
);

    localparam int          AW    = $clog2(MAX_FRAMES);
    localparam logic [20:0] MAX_N = 21'(MAX_FRAMES);

    item_t       item_reg;
    logic [31:0] mem [MAX_FRAMES];
    logic [31:0] rd_data_reg;
    logic [31:0] a_reg;

    logic [31:0] pos_reg;
    logic [15:0] vol_reg, tgt_reg;
    logic [15:0] fo_len_reg, fo_cnt_reg, fi_len_reg, fi_cnt_reg;
    logic        paused_reg, active_reg, pause_after_reg, stop_after_reg;

    logic signed [16:0] vl_reg, vr_reg;
    logic signed [18:0] scl_reg, scr_reg;

    logic [15:0] div_rem_reg;
    logic [16:0] div_quo_reg;
    logic [15:0] div_den_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg, div_done_reg;

    // frame bookkeeping
    logic [20:0] n_frames, f1;
    logic [15:0] f0;
    logic [31:0] addr_ext;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        render_ok, past_end, load_ok;
    logic [36:0] mark, mark_sat, np, endpos;

    assign n_frames = ({4'b0, cfg.frame_count} > MAX_N) ? MAX_N : {4'b0, cfg.frame_count};
    assign f0       = pos_reg[31:16];
    assign f1       = {5'b0, f0} + 21'd1;
    assign render_ok = active_reg && !paused_reg && (n_frames > 21'd1) && (f1 < n_frames);
    assign mark     = {n_frames, 16'b0};
    assign mark_sat = (|mark[36:32]) ? 37'h0FFFFFFFF : mark;
    assign past_end = ({5'b0, pos_reg} >= mark_sat);
    assign np       = {5'b0, pos_reg} + {17'b0, cfg.step_ratio};
    assign endpos   = {n_frames, 16'b0};

    assign addr_ext = cmd.rd_second ? {11'b0, f1} : {16'b0, f0};
    assign rd_addr  = addr_ext[AW-1:0];
    assign wr_addr  = AW'({16'b0, item_reg.frame_address});
    assign load_ok  = ({16'b0, item_reg.frame_address} < 32'(MAX_FRAMES));

    // fade remainders
    logic [16:0] fo_r, fi_r;
    logic        fo_rpos, fi_rpos;
    logic [16:0] div_nume;
    logic [15:0] div_den;
    assign fo_r    = {1'b0, fo_len_reg} - {1'b0, fo_cnt_reg};
    assign fi_r    = {1'b0, fi_len_reg} - {1'b0, fi_cnt_reg};
    assign fo_rpos = !fo_r[16] && (|fo_r);
    assign fi_rpos = !fi_r[16] && (|fi_r);
    assign div_nume = cmd.fi_start ? ({1'b0, tgt_reg} + {2'b0, fi_r[15:1]})
                                   : (17'd32768 + {2'b0, fo_r[15:1]});
    assign div_den  = cmd.fi_start ? fi_r[15:0] : fo_r[15:0];

    always_comb begin
        stat.command   = item_reg.command;
        stat.render_ok = render_ok;
        stat.tick_fade = active_reg && !(past_end && !cfg.loop_enable) && (tgt_reg != vol_reg);
        stat.fo_en     = (|fo_len_reg) && !paused_reg;
        stat.fo_rpos   = fo_rpos;
        stat.fi_en     = active_reg && (|fi_len_reg) && !paused_reg;
        stat.fi_rpos   = fi_rpos;
        stat.div_done  = div_done_reg;
    end

    // restoring divider, one quotient bit per cycle
    logic [16:0] div_shift, div_diff;
    logic        div_ge;
    assign div_shift = {div_rem_reg, div_quo_reg[16]};
    assign div_ge    = div_shift >= {1'b0, div_den_reg};
    assign div_diff  = div_shift - {1'b0, div_den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= 5'd0;
        end else begin
            div_done_reg <= div_busy_reg && (div_cnt_reg == 5'd16);
            if (cmd.fo_start || cmd.fi_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'd0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd16) div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fo_start || cmd.fi_start) begin
            div_rem_reg <= 16'd0;
            div_quo_reg <= div_nume;
            div_den_reg <= div_den;
        end else if (div_busy_reg) begin
            div_rem_reg <= div_ge ? div_diff[15:0] : div_shift[15:0];
            div_quo_reg <= {div_quo_reg[15:0], div_ge};
        end
    end

    // memory
    always_ff @(posedge aclk) begin
        if (cmd.exec && item_reg.command == CMD_LOAD && load_ok)
            mem[wr_addr] <= {item_reg.sample_right, item_reg.sample_left};
        rd_data_reg <= mem[rd_addr];
    end

    // interpolation and volume pipeline
    logic signed [16:0] dl, dr, t_s, vol_s, vl_next, vr_next;
    logic signed [33:0] pl, pr, pl_r, pr_r, ql, qr, ql_r, qr_r;
    assign dl    = $signed({rd_data_reg[15], rd_data_reg[15:0]})
                 - $signed({a_reg[15], a_reg[15:0]});
    assign dr    = $signed({rd_data_reg[31], rd_data_reg[31:16]})
                 - $signed({a_reg[31], a_reg[31:16]});
    assign t_s   = $signed({1'b0, pos_reg[15:0]});
    assign pl    = dl * t_s;
    assign pr    = dr * t_s;
    assign pl_r  = pl + 34'sd32768;
    assign pr_r  = pr + 34'sd32768;
    assign vl_next = $signed({a_reg[15], a_reg[15:0]}) + $signed(pl_r[32:16]);
    assign vr_next = $signed({a_reg[31], a_reg[31:16]}) + $signed(pr_r[32:16]);
    assign vol_s = $signed({1'b0, vol_reg});
    assign ql    = vl_reg * vol_s;
    assign qr    = vr_reg * vol_s;
    assign ql_r  = ql + 34'sd16384;
    assign qr_r  = qr + 34'sd16384;

    always_ff @(posedge aclk) begin
        if (cmd.latch) item_reg <= s_item;
        if (cmd.rd_second) a_reg <= rd_data_reg;
        if (cmd.mul_interp) begin
            vl_reg <= vl_next;
            vr_reg <= vr_next;
        end
        if (cmd.exec) begin
            scl_reg <= 19'sd0;
            scr_reg <= 19'sd0;
        end else if (cmd.mul_volume) begin
            scl_reg <= $signed(ql_r[33:15]);
            scr_reg <= $signed(qr_r[33:15]);
        end
    end

    // output register
    logic signed [19:0] sum_l, sum_r;
    assign sum_l = $signed({{4{item_reg.mix_left[15]}}, item_reg.mix_left})
                 + $signed({scl_reg[18], scl_reg});
    assign sum_r = $signed({{4{item_reg.mix_right[15]}}, item_reg.mix_right})
                 + $signed({scr_reg[18], scr_reg});

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_left  <= (sum_l > 20'sd32767) ? 16'h7FFF :
                         (sum_l < -20'sd32768) ? 16'h8000 : sum_l[15:0];
            out_right <= (sum_r > 20'sd32767) ? 16'h7FFF :
                         (sum_r < -20'sd32768) ? 16'h8000 : sum_r[15:0];
            voice_active   <= active_reg;
            voice_paused   <= paused_reg;
            current_volume <= vol_reg;
        end
    end

    // fade arithmetic
    logic signed [17:0] fo_v;
    logic [17:0]        fi_v;
    assign fo_v = fo_rpos ? ($signed({2'b0, vol_reg}) - $signed({1'b0, div_quo_reg})) : 18'sd0;
    assign fi_v = fi_rpos ? ({2'b0, vol_reg} + {1'b0, div_quo_reg}) : {2'b0, tgt_reg};

    // voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= 32'd0;
            vol_reg         <= VOL_DEFAULT;
            tgt_reg         <= VOL_DEFAULT;
            fo_len_reg      <= 16'd0;
            fo_cnt_reg      <= 16'd0;
            fi_len_reg      <= 16'd0;
            fi_cnt_reg      <= 16'd0;
            paused_reg      <= 1'b0;
            active_reg      <= 1'b0;
            pause_after_reg <= 1'b0;
            stop_after_reg  <= 1'b0;
        end else if (cmd.exec) begin
            if (item_reg.command == CMD_START) begin
                active_reg      <= 1'b1;
                pos_reg         <= 32'd0;
                vol_reg         <= VOL_DEFAULT;
                tgt_reg         <= VOL_DEFAULT;
                fo_len_reg      <= 16'd0;
                fo_cnt_reg      <= 16'd0;
                fi_len_reg      <= 16'd0;
                fi_cnt_reg      <= 16'd0;
                paused_reg      <= 1'b0;
                pause_after_reg <= 1'b0;
                stop_after_reg  <= 1'b0;
            end else if (active_reg) begin
                case (item_reg.command)
                    CMD_TICK: begin
                        if (past_end) begin
                            if (cfg.loop_enable) pos_reg <= {cfg.loop_start, 16'b0};
                            else active_reg <= 1'b0;
                        end
                    end
                    CMD_SETVOL:    vol_reg <= item_reg.volume_value;
                    CMD_SETTARGET: tgt_reg <= item_reg.volume_value;
                    CMD_PAUSE:     paused_reg <= 1'b1;
                    CMD_RESUME: begin
                        paused_reg <= 1'b0;
                        fi_len_reg <= item_reg.fade_steps;
                    end
                    CMD_FADEPAUSE: begin
                        fo_len_reg      <= item_reg.fade_steps;
                        tgt_reg         <= 16'd0;
                        pause_after_reg <= 1'b1;
                    end
                    CMD_FADESTOP: begin
                        fo_len_reg     <= item_reg.fade_steps;
                        tgt_reg        <= 16'd0;
                        stop_after_reg <= 1'b1;
                    end
                    CMD_FADEIN: begin
                        fi_len_reg <= item_reg.fade_steps;
                        tgt_reg    <= item_reg.volume_value;
                    end
                    CMD_STOP: active_reg <= 1'b0;
                    default: ;
                endcase
            end
        end else if (cmd.mul_volume) begin
            if (np >= endpos) begin
                if (cfg.loop_enable) begin
                    pos_reg <= {cfg.loop_start, 16'b0};
                end else begin
                    paused_reg <= 1'b1;
                    pos_reg    <= (|np[36:32]) ? 32'hFFFF_FFFF : np[31:0];
                end
            end else begin
                pos_reg <= np[31:0];
            end
        end else if (cmd.fo_apply) begin
            if (fo_v <= 18'sd0) begin
                vol_reg    <= 16'd0;
                fo_len_reg <= 16'd0;
                fo_cnt_reg <= 16'd0;
                if (pause_after_reg) paused_reg <= 1'b1;
                else if (stop_after_reg) active_reg <= 1'b0;
            end else begin
                vol_reg    <= fo_v[15:0];
                fo_cnt_reg <= fo_cnt_reg + 16'd1;
            end
        end else if (cmd.fi_apply) begin
            if (fi_v >= {2'b0, tgt_reg}) begin
                vol_reg    <= tgt_reg;
                fi_len_reg <= 16'd0;
                fi_cnt_reg <= 16'd0;
            end else begin
                vol_reg    <= fi_v[15:0];
                fi_cnt_reg <= fi_cnt_reg + 16'd1;
            end
        end
    end

    `SSV_ASSERT_IMP(a_div_idle_when_done, aclk, aresetn, div_done_reg, !div_busy_reg, "divider still busy at completion")
    `SSV_ASSERT_NXT(a_fade_in_clamped, aclk, aresetn, cmd.fi_apply, vol_reg <= tgt_reg, "fade-in overshot target")

endmodule

/* hw/rtl/ssv_ctrl.sv */
// ----------------------------------------------------------------------------
// ssv_ctrl
// Sequencer: accepts a transaction, steps the datapath, hands out any render result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssv_ctrl
    import ssv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EXEC    = 4'd1;
    localparam logic [3:0] ST_RD0     = 4'd2;
    localparam logic [3:0] ST_RD1     = 4'd3;
    localparam logic [3:0] ST_MUL1    = 4'd4;
    localparam logic [3:0] ST_MUL2    = 4'd5;
    localparam logic [3:0] ST_OUT     = 4'd6;
    localparam logic [3:0] ST_FO_CHK  = 4'd7;
    localparam logic [3:0] ST_FO_WAIT = 4'd8;
    localparam logic [3:0] ST_FI_CHK  = 4'd9;
    localparam logic [3:0] ST_FI_WAIT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.command == CMD_RENDER)
                    state_next = stat.render_ok ? ST_RD0 : ST_OUT;
                else if (stat.command == CMD_TICK && stat.tick_fade)
                    state_next = ST_FO_CHK;
                else
                    state_next = ST_IDLE;
            end
            ST_RD0: begin
                cmd.rd_first = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_second = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_interp = 1'b1;
                state_next     = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_volume = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FO_CHK: begin
                if (!stat.fo_en) begin
                    state_next = ST_FI_CHK;
                end else if (stat.fo_rpos) begin
                    cmd.fo_start = 1'b1;
                    state_next   = ST_FO_WAIT;
                end else begin
                    cmd.fo_apply = 1'b1;
                    state_next   = ST_FI_CHK;
                end
            end
            ST_FO_WAIT: begin
                if (stat.div_done) begin
                    cmd.fo_apply = 1'b1;
                    state_next   = ST_FI_CHK;
                end
            end
            ST_FI_CHK: begin
                if (!stat.fi_en) begin
                    state_next = ST_IDLE;
                end else if (stat.fi_rpos) begin
                    cmd.fi_start = 1'b1;
                    state_next   = ST_FI_WAIT;
                end else begin
                    cmd.fi_apply = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FI_WAIT: begin
                if (stat.div_done) begin
                    cmd.fi_apply = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `SSV_ASSERT_IMP(a_out_load_free, aclk, aresetn, cmd.out_load, (!m_tvalid_reg || m_tready), "result overwritten while pending")
    `SSV_ASSERT_NXT(a_accept_exec, aclk, aresetn, (s_tvalid && s_tready), (state_reg == ST_EXEC), "accepted transaction not executed")

endmodule

/* hw/rtl/stereo_sample_voice_with_fades.sv */
// Render: the transaction is latched and executed, then come two reads of the sample memory
// through its single read port, then interpolate, scale and sum; no new transaction is taken
// before the result is loaded. A silent or paused voice passes the mix through.
// Load and other commands: latch and execute. Tick: the same, and with fades
// the bit-serial fade divider runs once per active ramp that has steps left.
// Reset (aresetn low, synchronous) clears control and voice state; memory is not cleared.
// ----------------------------------------------------------------------------
// stereo_sample_voice_with_fades
// Stereo sample-playback voice with interpolation, volume and fade ramps.
// ----------------------------------------------------------------------------
module stereo_sample_voice_with_fades
    import ssv_pkg::*;
#(
    parameter int MAX_FRAMES = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    // frame_address, sample_left, sample_right, mix_left, mix_right,
    // fade_steps, volume_value (16 bits each)
    input  logic [111:0] s_tdata,
    input  logic [3:0]   s_tuser,   // command
    input  logic         s_tvalid,
    output logic         s_tready,
    // out_left, out_right, voice_active, voice_paused, current_volume, zero pad
    output logic [55:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t     cfg_reg;
    item_t    s_item;
    ctl_cmd_t cmd;
    dp_stat_t stat;

    logic [15:0] out_left, out_right, current_volume;
    logic        voice_active, voice_paused;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_ratio  <= STEP_RATIO_RST;
            cfg_reg.frame_count <= 17'd0;
            cfg_reg.loop_start  <= 16'd0;
            cfg_reg.loop_enable <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_STEP_RATIO:  cfg_reg.step_ratio  <= pwdata[19:0];
                REG_FRAME_COUNT: cfg_reg.frame_count <= pwdata[16:0];
                REG_LOOP_START:  cfg_reg.loop_start  <= pwdata[15:0];
                REG_LOOP_ENABLE: cfg_reg.loop_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STEP_RATIO:  prdata = {12'b0, cfg_reg.step_ratio};
            REG_FRAME_COUNT: prdata = {15'b0, cfg_reg.frame_count};
            REG_LOOP_START:  prdata = {16'b0, cfg_reg.loop_start};
            REG_LOOP_ENABLE: prdata = {31'b0, cfg_reg.loop_enable};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        s_item.command       = s_tuser;
        s_item.frame_address = s_tdata[15:0];
        s_item.sample_left   = s_tdata[31:16];
        s_item.sample_right  = s_tdata[47:32];
        s_item.mix_left      = s_tdata[63:48];
        s_item.mix_right     = s_tdata[79:64];
        s_item.fade_steps    = s_tdata[95:80];
        s_item.volume_value  = s_tdata[111:96];
    end

    assign m_tdata = {6'b0, current_volume, voice_paused, voice_active, out_right, out_left};

    ssv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssv_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_item         (s_item),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .stat           (stat),
        .out_left       (out_left),
        .out_right      (out_right),
        .voice_active   (voice_active),
        .voice_paused   (voice_paused),
        .current_volume (current_volume)
    );

endmodule

/* tb/stereo_sample_voice_with_fades_test.sv */
// ----------------------------------------------------------------------------
// stereo_sample_voice_with_fades_test
// Self-checking bench for the stereo playback voice: a directed pass over
// every command but SETTARGET and the edge cases, then random command streams under several
// register settings. A built-in voice predictor scores every render result.
// ----------------------------------------------------------------------------
module stereo_sample_voice_with_fades_test
    import ssv_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAMES    = 65536;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 60;

    typedef struct {
        logic [15:0] out_left;
        logic [15:0] out_right;
        logic        voice_active;
        logic        voice_paused;
        logic [15:0] current_volume;
    } mix_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [111:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    stereo_sample_voice_with_fades uut (.*);

    always #6 aclk = ~aclk;

    // voice model state
    logic [31:0] frame_mem [NFRAMES];
    bit          frame_written [NFRAMES];
    logic [31:0] play_pos;
    logic [15:0] vol_level, tgt_level, fo_len, fo_cnt, fi_len, fi_cnt;
    bit          v_paused, v_active, pause_on_fade, stop_on_fade;
    logic [19:0] cfg_step;
    logic [16:0] cfg_frames;
    logic [15:0] cfg_loop_start;
    bit          cfg_loop;

    mix_out_t expected_mix[$];
    int  fail_count = 0;
    int  n_render = 0, n_tick = 0, n_load = 0, n_other = 0, n_results = 0;
    int  idle_cycles = 0;
    bit  accepted_apb = 1'b0;
    bit  calm = 1'b0;      // no idling on either side while set
    int  stall_left = 0;

    function automatic longint used_frames();
        return (cfg_frames > NFRAMES) ? NFRAMES : longint'(cfg_frames);
    endfunction

    function automatic longint sx(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [15:0] sat16(longint x);
        if (x > 32767) return 16'h7fff;
        if (x < -32768) return 16'h8000;
        return x[15:0];
    endfunction

    function automatic void fade_out_tick();
        int r, v;
        if (fo_len == 0 || v_paused) return;
        r = int'(fo_len) - int'(fo_cnt);
        if (r > 0) v = int'(vol_level) - (32768 + (r >> 1)) / r;
        else v = 0;
        fo_cnt = fo_cnt + 16'd1;
        if (v <= 0) begin
            v = 0;
            fo_len = '0;
            fo_cnt = '0;
            if (pause_on_fade) v_paused = 1'b1;
            else if (stop_on_fade) v_active = 1'b0;
        end
        vol_level = v[15:0];
    endfunction

    function automatic void fade_in_tick();
        int r;
        int unsigned v;
        if (fi_len == 0 || v_paused) return;
        r = int'(fi_len) - int'(fi_cnt);
        if (r > 0) v = vol_level + (int'(tgt_level) + (r >> 1)) / r;
        else v = 32'(tgt_level);
        fi_cnt = fi_cnt + 16'd1;
        if (v >= tgt_level) begin
            v = 32'(tgt_level);
            fi_len = '0;
            fi_cnt = '0;
        end
        vol_level = v[15:0];
    endfunction

    function automatic void subframe_tick();
        longint mark;
        mark = used_frames() << 16;
        if (mark > 64'hffffffff) mark = 64'hffffffff;
        if (longint'(play_pos) >= mark) begin
            if (cfg_loop) play_pos = {cfg_loop_start, 16'h0};
            else begin
                v_active = 1'b0;
                return;
            end
        end
        if (tgt_level != vol_level) begin
            fade_out_tick();
            if (v_active) fade_in_tick();
        end
    endfunction

    // interpolate one channel (the caller passes that lane's halves), scale by volume
    function automatic longint voice_lane(logic [15:0] a, logic [15:0] b, longint t);
        longint s0, v;
        s0 = sx(a);
        v = s0 + (((sx(b) - s0) * t + 32768) >>> 16);
        return (v * longint'(vol_level) + 16384) >>> 15;
    endfunction

    function automatic mix_out_t render_mix(logic [15:0] ml, logic [15:0] mr);
        mix_out_t o;
        longint n, f0, np, t;
        logic [31:0] a, b;
        o.out_left = ml;
        o.out_right = mr;
        n = used_frames();
        if (v_active && !v_paused && n > 1) begin
            f0 = play_pos >> 16;
            if (f0 + 1 < n) begin
                a = frame_mem[f0];
                b = frame_mem[f0 + 1];
                t = play_pos[15:0];
                o.out_left  = sat16(sx(ml) + voice_lane(a[15:0], b[15:0], t));
                o.out_right = sat16(sx(mr) + voice_lane(a[31:16], b[31:16], t));
                np = longint'(play_pos) + cfg_step;
                if (np >= (n << 16)) begin
                    if (cfg_loop) np = longint'(cfg_loop_start) << 16;
                    else begin
                        v_paused = 1'b1;
                        if (np > 64'hffffffff) np = 64'hffffffff;
                    end
                end
                play_pos = np[31:0];
            end
        end
        o.voice_active = v_active;
        o.voice_paused = v_paused;
        o.current_volume = vol_level;
        return o;
    endfunction

    function automatic void apply_command(item_t it);
        if (it.command == CMD_LOAD) begin
            frame_mem[it.frame_address] = {it.sample_right, it.sample_left};
            frame_written[it.frame_address] = 1'b1;
            return;
        end
        if (it.command == CMD_RENDER) begin
            expected_mix.push_back(render_mix(it.mix_left, it.mix_right));
            return;
        end
        if (it.command == CMD_START) begin
            v_active = 1'b1;
            play_pos = '0;
            vol_level = VOL_DEFAULT;
            tgt_level = VOL_DEFAULT;
            fo_len = '0; fo_cnt = '0; fi_len = '0; fi_cnt = '0;
            v_paused = 1'b0; pause_on_fade = 1'b0; stop_on_fade = 1'b0;
            return;
        end
        if (!v_active) return;
        case (it.command)
            CMD_TICK:      subframe_tick();
            CMD_SETVOL:    vol_level = it.volume_value;
            CMD_SETTARGET: tgt_level = it.volume_value;
            CMD_PAUSE:     v_paused = 1'b1;
            CMD_RESUME: begin
                v_paused = 1'b0;
                fi_len = it.fade_steps;
            end
            CMD_FADEPAUSE: begin
                fo_len = it.fade_steps;
                tgt_level = '0;
                pause_on_fade = 1'b1;
            end
            CMD_FADESTOP: begin
                fo_len = it.fade_steps;
                tgt_level = '0;
                stop_on_fade = 1'b1;
            end
            CMD_FADEIN: begin
                fi_len = it.fade_steps;
                tgt_level = it.volume_value;
            end
            CMD_STOP:      v_active = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_t noise_item(logic [3:0] cmd);
        item_t it;
        it.command = cmd;
        it.frame_address = 16'($urandom);
        it.sample_left = 16'($urandom);
        it.sample_right = 16'($urandom);
        it.mix_left = 16'($urandom);
        it.mix_right = 16'($urandom);
        it.fade_steps = 16'($urandom);
        it.volume_value = 16'($urandom_range(0, 32768));
        return it;
    endfunction

    // one input transaction; valid stays high into the next call when no gap
    task automatic send_item(item_t it);
        int g;
        s_tdata <= {it.volume_value, it.fade_steps, it.mix_right, it.mix_left,
                    it.sample_right, it.sample_left, it.frame_address};
        s_tuser <= it.command;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_command(it);
        case (it.command)
            CMD_RENDER: n_render++;
            CMD_TICK:   n_tick++;
            CMD_LOAD:   n_load++;
            default:    n_other++;
        endcase
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic load_frame(logic [15:0] addr, logic [15:0] l, logic [15:0] r);
        item_t it;
        it = noise_item(CMD_LOAD);
        it.frame_address = addr;
        it.sample_left = l;
        it.sample_right = r;
        send_item(it);
    endtask

    // the two frames a render reads must hold data first
    task automatic fill_render_frames();
        longint f0;
        if (!v_active || v_paused || used_frames() <= 1) return;
        f0 = play_pos >> 16;
        if (f0 + 1 >= used_frames()) return;
        for (longint k = f0; k <= f0 + 1; k++)
            if (!frame_written[k]) load_frame(k[15:0], 16'($urandom), 16'($urandom));
    endtask

    task automatic render(logic [15:0] ml, logic [15:0] mr);
        item_t it;
        fill_render_frames();
        it = noise_item(CMD_RENDER);
        it.mix_left = ml;
        it.mix_right = mr;
        send_item(it);
    endtask

    task automatic command(logic [3:0] cmd, logic [15:0] steps, logic [15:0] vol);
        item_t it;
        it = noise_item(cmd);
        it.fade_steps = steps;
        it.volume_value = vol;
        send_item(it);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        accepted_apb = 1'b1;
        case (idx)
            REG_STEP_RATIO:  cfg_step = val[19:0];
            REG_FRAME_COUNT: cfg_frames = val[16:0];
            REG_LOOP_START:  cfg_loop_start = val[15:0];
            REG_LOOP_ENABLE: cfg_loop = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [19:0] step, logic [16:0] frames,
                            logic [15:0] lstart, bit lp);
        wait_idle();
        reg_write(REG_STEP_RATIO, 32'(step));
        reg_write(REG_FRAME_COUNT, 32'(frames));
        reg_write(REG_LOOP_START, 32'(lstart));
        reg_write(REG_LOOP_ENABLE, 32'(lp));
    endtask

    task automatic test_directed();
        render(16'h7fff, 16'h8000);              // no voice: mix passes through
        command(CMD_SETVOL, 16'd0, 16'd32768);   // ignored without a voice
        set_regs(20'd65536, 17'd4, 16'd0, 1'b1);
        load_frame(16'd0, 16'h7fff, 16'h8000);
        load_frame(16'd1, 16'h8000, 16'h7fff);
        load_frame(16'd2, 16'h0000, 16'hffff);
        load_frame(16'd3, 16'h7fff, 16'h7fff);
        load_frame(16'hffff, 16'h1234, 16'h5678);
        command(CMD_START, 16'd0, 16'd0);
        command(CMD_SETVOL, 16'd0, 16'd32768);
        render(16'h7fff, 16'h8000);              // saturation both ways
        render(16'h8000, 16'h7fff);
        command(CMD_TICK, 16'd0, 16'd0);
        command(CMD_PAUSE, 16'd0, 16'd0);
        render(16'h0100, 16'h0200);              // paused: pass through
        command(CMD_RESUME, 16'd3, 16'd0);
        command(CMD_FADEPAUSE, 16'd3, 16'd0);
        repeat (4) command(CMD_TICK, 16'd0, 16'd0);
        render(16'h0000, 16'h0000);
        command(CMD_RESUME, 16'd2, 16'd0);
        command(CMD_FADEIN, 16'd2, 16'd32768);
        repeat (3) command(CMD_TICK, 16'd0, 16'd0);
        command(CMD_FADESTOP, 16'd0, 16'd0);     // zero length: no ramp runs
        command(CMD_TICK, 16'd0, 16'd0);
        command(4'd12, 16'd0, 16'd0);
        command(4'd15, 16'hffff, 16'd0);
        command(CMD_STOP, 16'd0, 16'd0);
        render(16'h1111, 16'h2222);
    endtask

    task automatic random_item();
        int p;
        p = $urandom_range(0, 99);
        if (!v_active && p < 70)
            command(CMD_START, 16'($urandom), 16'($urandom_range(0, 32768)));
        else if (p < 45) render(16'($urandom), 16'($urandom));
        else if (p < 65) command(CMD_TICK, 16'($urandom), 16'($urandom));
        else if (p < 72) load_frame(16'($urandom_range(0, 63)), 16'($urandom),
                                    16'($urandom));
        else if (p < 74) command(CMD_START, 16'($urandom), 16'($urandom));
        else if (p < 77) command(CMD_SETVOL, 16'd0, 16'($urandom_range(0, 32768)));
        else if (p < 80) command(CMD_SETTARGET, 16'd0, 16'($urandom_range(0, 32768)));
        else if (p < 82) command(CMD_PAUSE, 16'd0, 16'd0);
        else if (p < 86) command(CMD_RESUME, 16'($urandom_range(0, 6)), 16'd0);
        else if (p < 89) command(CMD_FADEPAUSE,
                                 ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 8)),
                                 16'd0);
        else if (p < 92) command(CMD_FADESTOP, 16'($urandom_range(0, 8)), 16'd0);
        else if (p < 96) command(CMD_FADEIN,
                                 ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 8)),
                                 16'($urandom_range(0, 32768)));
        else if (p < 98) command(CMD_STOP, 16'd0, 16'd0);
        else command(4'($urandom_range(12, 15)), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random_phase(logic [19:0] step, logic [16:0] frames,
                                     logic [15:0] lstart, bit lp, int count);
        set_regs(step, frames, lstart, lp);
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) random_item();
        calm = 1'b0;
    endtask

    // result scoring
    always @(posedge aclk) begin
        mix_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_mix.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                fail_count++;
            end else begin
                e = expected_mix.pop_front();
                if (m_tdata[15:0] !== e.out_left) begin
                    $error("out_left exp %h got %h", e.out_left, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[31:16] !== e.out_right) begin
                    $error("out_right exp %h got %h", e.out_right, m_tdata[31:16]);
                    fail_count++;
                end
                if (m_tdata[32] !== e.voice_active) begin
                    $error("voice_active exp %b got %b", e.voice_active, m_tdata[32]);
                    fail_count++;
                end
                if (m_tdata[33] !== e.voice_paused) begin
                    $error("voice_paused exp %b got %b", e.voice_paused, m_tdata[33]);
                    fail_count++;
                end
                if (m_tdata[49:34] !== e.current_volume) begin
                    $error("current_volume exp %h got %h", e.current_volume, m_tdata[49:34]);
                    fail_count++;
                end
            end
        end
    end

    // result-side back-pressure
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || accepted_apb) begin
            idle_cycles <= 0;
            accepted_apb = 1'b0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        play_pos = '0;
        vol_level = VOL_DEFAULT; tgt_level = VOL_DEFAULT;
        fo_len = '0; fo_cnt = '0; fi_len = '0; fi_cnt = '0;
        v_paused = 0; v_active = 0; pause_on_fade = 0; stop_on_fade = 0;
        cfg_step = STEP_RATIO_RST; cfg_frames = '0; cfg_loop_start = '0; cfg_loop = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(20'd65536, 17'd8, 16'd0, 1'b1, 160);
        test_random_phase(20'd0, 17'd2, 16'd0, 1'b1, 100);
        test_random_phase(20'hfffff, 17'd40, 16'd3, 1'b1, 150);
        test_random_phase(20'd23456, 17'd12, 16'd5, 1'b0, 180);
        test_random_phase(20'd70000, 17'd1, 16'd0, 1'b1, 80);
        test_random_phase(20'd0, 17'd0, 16'hffff, 1'b0, 80);
        test_random_phase(20'd40000, 17'd20, 16'hffff, 1'b1, 150);
        test_random_phase(20'hfffff, 17'd65536, 16'd0, 1'b0, 150);
        test_random_phase(20'd1000, 17'h1ffff, 16'd2, 1'b1, 120);
        test_random_phase(20'($urandom_range(0, 20'hfffff)), 17'($urandom_range(2, 30)),
                          16'($urandom_range(0, 31)), 1'b0, 200);
        test_random_phase(20'($urandom_range(0, 200000)), 17'($urandom_range(2, 30)),
                          16'($urandom_range(0, 31)), 1'b1, 250);

        wait_idle();
        $display("covered %0d renders, %0d ticks, %0d loads, %0d other commands",
                 n_render, n_tick, n_load, n_other);
        $display("%0d result transactions scored over 12 register settings", n_results);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ssv_pkg.sv
hw/rtl/ssv_datapath.sv
hw/rtl/ssv_ctrl.sv
hw/rtl/stereo_sample_voice_with_fades.sv
tb/stereo_sample_voice_with_fades_test.sv
